// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int KEY_W            = 32;
  localparam int COUNT_OUT_W      = 7;
  localparam int DEFAULT_CAPACITY = 127;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic action;
    key_t key;
  } req_item_t;

  typedef struct packed {
    key_t                   max_key;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic insert;
    logic remove;
    key_t key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/mhpq_cell.sv =====
module mhpq_cell (
  input  logic               clk,
  input  mhpq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               left_ge,
  input  mhpq_pkg::key_t     left_key,
  input  mhpq_pkg::key_t     right_key,
  output mhpq_pkg::key_t     key,
  output logic               ge
);
  import mhpq_pkg::*;

  // this cell keeps its key on insert when it holds a key no smaller
  assign ge = occupied && (key >= ctrl.key);

  // remove shifts toward the head; insert shifts away from it below the slot
  always_ff @(posedge clk) begin
    if (ctrl.remove) begin
      key <= right_key;
    end else if (ctrl.insert && !ge) begin
      key <= left_ge ? ctrl.key : left_key;
    end
  end

endmodule

// ===== rtl/core/max_heap_priority_queue.sv =====
// Max priority queue of signed 32-bit keys.
// Request channel (req_valid / req_stall / req): action selects insert or
// remove-max; key is used on insert only. Response channel (rsp_valid /
// rsp_stall / rsp): exactly one item per request, carrying the removed
// maximum (zero unless a remove succeeded), a status (ok, empty, full) and
// the number of keys held afterwards.
// Keys sit sorted, largest first, in a row of CAPACITY cells. An insert
// compares the new key against every cell at once and each cell either
// keeps its key, takes the new key or takes its left neighbor's key; a
// remove shifts every cell one place toward the head.
// The response is registered and appears in the cycle after the request is
// accepted. Throughput: one item per cycle while the response side takes
// every item; for either action the cell row updates as the request is accepted.
// While a response waits under rsp_stall, req_stall is raised; it drops in
// the cycle the response is taken, so a new request enters then.
// Reset empties the queue (count to zero) and clears rsp_valid; cell
// contents are not cleared, unused cells are never reported.
// An insert into a full queue is dropped; a remove on an empty queue
// reports empty and zero.
module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mhpq_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mhpq_pkg::rsp_item_t rsp
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic          full;
  logic          empty;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  cell_ctrl_t    ctrl;
  key_t          cell_key [CAPACITY];
  logic          cell_ge  [CAPACITY];
  rsp_item_t     rsp_next;

  // handshake: hold requests while a response is waiting
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count >= CW'(CAPACITY));
  assign empty = (count == '0);

  assign ctrl.insert = accept && (req.action == ACT_INSERT) && !full;
  assign ctrl.remove = accept && (req.action == ACT_REMOVE) && !empty;
  assign ctrl.key    = req.key;

  // count update
  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CW'(1);
    end else if (ctrl.remove) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // row of cells, head (largest key) at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    logic lge;
    key_t lkey;
    key_t rkey;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign lge  = 1'b1;
      assign lkey = ctrl.key;
    end else begin : g_body
      assign lge  = cell_ge[i-1];
      assign lkey = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rkey = cell_key[i];
    end else begin : g_mid
      assign rkey = cell_key[i+1];
    end

    mhpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_ge   (lge),
      .left_key  (lkey),
      .right_key (rkey),
      .key       (cell_key[i]),
      .ge        (cell_ge[i])
    );
  end

  // response item
  always_comb begin
    rsp_next.max_key     = ctrl.remove ? cell_key[0] : '0;
    rsp_next.entry_count = COUNT_OUT_W'(count_next);
    if (req.action == ACT_INSERT) begin
      rsp_next.status = full ? ST_FULL : ST_OK;
    end else begin
      rsp_next.status = empty ? ST_EMPTY : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== sim/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;

  import mhpq_pkg::*;

  localparam int HEAP_CAP = DEFAULT_CAPACITY;
  localparam int MAX_SHOWN = 10;
  localparam key_t KEY_MAX = 32'sh7fff_ffff;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // idle/stall odds in percent, changed per phase
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  // shadow heap: keys at 1..heap_fill
  key_t heap_keys [1:HEAP_CAP];
  int   heap_fill = 0;

  rsp_item_t expected_rsps [$];
  int        items_sent = 0;
  int        rsps_seen = 0;
  int        error_count = 0;

  max_heap_priority_queue #(
    .CAPACITY(HEAP_CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one item to the shadow heap, return the result it should produce
  function automatic rsp_item_t predict_heap_step(req_item_t item);
    rsp_item_t res;
    key_t      tmp;
    int        pos;
    int        best;
    res = '0;
    res.status = ST_OK;
    if (item.action == ACT_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        res.status = ST_FULL;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = item.key;
        pos = heap_fill;
        // sift up while strictly greater than parent
        while (pos > 1 && heap_keys[pos] > heap_keys[pos / 2]) begin
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[pos / 2];
          heap_keys[pos / 2] = tmp;
          pos = pos / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.max_key = heap_keys[1];
        heap_keys[1] = heap_keys[heap_fill];
        heap_fill--;
        pos = 1;
        // sift down: larger child, left on tie, only while strictly greater
        forever begin
          best = pos;
          if (2 * pos <= heap_fill && heap_keys[2 * pos] > heap_keys[best])
            best = 2 * pos;
          if (2 * pos + 1 <= heap_fill && heap_keys[2 * pos + 1] > heap_keys[best])
            best = 2 * pos + 1;
          if (best == pos)
            break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.entry_count = heap_fill[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic note_error(string what, logic [31:0] exp_val, logic [31:0] got_val);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_val, got_val);
  endtask

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (req_valid && !req_stall)
        expected_rsps.push_back(predict_heap_step(req));
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        if (expected_rsps.size() == 0) begin
          note_error("unexpected result", 32'h0, rsp.max_key);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.max_key !== want.max_key)
            note_error("max_key", want.max_key, rsp.max_key);
          if (rsp.status !== want.status)
            note_error("status", 32'(want.status), 32'(rsp.status));
          if (rsp.entry_count !== want.entry_count)
            note_error("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // present one item, with a random gap ahead of it, and wait until it is taken
  task automatic send_item(logic action, key_t key);
    req_item_t item;
    item.action = action;
    item.key = key;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender off until every result is back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (rsps_seen < items_sent) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(3))
      0: return key_t'($urandom_range(8)) - 4;
      1: begin
        case ($urandom_range(3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  // empty remove, extreme keys, repeated keys, then empty again
  task automatic test_directed();
    send_item(ACT_REMOVE, '0);
    send_item(ACT_INSERT, KEY_MAX);
    send_item(ACT_INSERT, KEY_MIN);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, -1);
    send_item(ACT_INSERT, 1);
    send_item(ACT_INSERT, 32'sh5555_5555);
    send_item(ACT_INSERT, 32'shaaaa_aaaa);
    send_item(ACT_INSERT, 7);
    send_item(ACT_INSERT, 7);
    send_item(ACT_INSERT, 7);
    repeat (10) send_item(ACT_REMOVE, KEY_MAX);
    send_item(ACT_REMOVE, -1);
    wait_for_drain();
  endtask

  // fill to capacity, push into the full heap, then empty it completely
  task automatic test_full_heap();
    while (heap_fill > 0) send_item(ACT_REMOVE, pick_key());
    repeat (HEAP_CAP) send_item(ACT_INSERT, pick_key());
    send_item(ACT_INSERT, KEY_MAX);
    send_item(ACT_INSERT, KEY_MIN);
    wait_for_drain();
    repeat (HEAP_CAP + 2) send_item(ACT_REMOVE, pick_key());
    wait_for_drain();
  endtask

  // random traffic in segments that push the fill level up, down or hold it level
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    int left;
    int seg_len;
    int insert_pct;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    left = n_items;
    while (left > 0) begin
      seg_len = $urandom_range(150, 20);
      case ($urandom_range(3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < seg_len && left > 0; i++) begin
        if ($urandom_range(99) < insert_pct)
          send_item(ACT_INSERT, pick_key());
        else
          send_item(ACT_REMOVE, pick_key());
        left--;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_heap();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 87, 0);
    test_random_traffic(400, 0, 87);
    test_random_traffic(400, 27, 27);
    repeat (5) @(posedge clk);
    if (expected_rsps.size() != 0)
      note_error("missing results", 32'(expected_rsps.size()), 32'h0);
    if (error_count == 0)
      $display("tb_max_heap_priority_queue: done, clean");
    else
      $display("tb_max_heap_priority_queue: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_max_heap_priority_queue: done, errors");
    $finish;
  end

endmodule
